// File: hdl/robin_hood_hash_table_macros.svh
// assertion macros shared by the checker
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH

// clocked property, off while reset is asserted
`define RHHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition that must never be seen
`define RHHT_NEVER(label, cond, msg) \
    `RHHT_ASSERT(label, !(cond), msg)

`endif

// File: hdl/rhht_pkg.sv
`default_nettype none

package rhht_pkg;

    localparam int SLOTS      = 1024;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam logic [7:0]  TAG_EMPTY   = 8'h80;
    localparam logic [10:0] MAX_DEFAULT = 11'd768;

    // request kinds as they arrive
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXISTS    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_REMOVE,
        OP_INVALID
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [63:0] hash;
        logic [63:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [10:0] entry_count;
    } out_t;

    // classified request handed from front to engine
    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [63:0]           hash;
        logic [VALUE_BITS-1:0] value;
    } job_t;

    // one slot of the table
    typedef struct packed {
        logic [7:0]            tag;
        logic [63:0]           hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } word_t;

    localparam word_t EMPTY_WORD = '{tag: TAG_EMPTY, default: '0};

endpackage

`default_nettype wire

// File: hdl/robin_hood_hash_table.sv
// lookup: probes slots one after another from the home slot, then loads the result register
// insert adds the placement walk, up to and including the empty slot
// remove adds a clear, a scan of the cluster's slots and an extra clearing step per back-shift
// throughput: one transaction in the engine at a time, set by the single slot memory port
// a two-deep queue takes new transactions while the engine works or a result waits
// reset: synchronous, active low; then a clearing pass marks every slot empty,
// with s_ready low until it ends (configuration writes still taken)
`default_nettype none

module robin_hood_hash_table (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rhht_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rhht_pkg::out_t      m_data,
    input  wire logic           cfg_we,
    input  wire logic [10:0]    cfg_wdata
);
    import rhht_pkg::*;

    // classified transaction from front to engine
    job_t job;
    logic job_valid;
    logic job_pop;
    logic init_done;

    // front: classifies the kind, trims key and value, queues two deep
    rhht_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .init_done (init_done),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // engine: probe walk, robin hood insert, backward-shift remove, result register
    rhht_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .init_done (init_done),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: hdl/rhht_front.sv
`default_nettype none

module rhht_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rhht_pkg::in_t s_data,
    input  wire logic          init_done,
    output logic               job_valid,
    output rhht_pkg::job_t     job,
    input  wire logic          job_pop
);
    import rhht_pkg::*;

    job_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       in_job;
    logic       push;

    always_comb begin
        case (s_data.kind)
            KIND_INSERT: in_job.op = OP_INSERT;
            KIND_LOOKUP: in_job.op = OP_LOOKUP;
            KIND_REMOVE: in_job.op = OP_REMOVE;
            default:     in_job.op = OP_INVALID;
        endcase
        in_job.key   = s_data.key[KEY_BITS-1:0];
        in_job.hash  = s_data.hash;
        in_job.value = s_data.value[VALUE_BITS-1:0];
    end

    assign s_ready   = (cnt_reg != 2'd2) && init_done;
    assign push      = s_valid && s_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = job_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(job_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            q_reg[wp_reg] <= in_job;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rhht_engine.sv
`default_nettype none

module rhht_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           job_valid,
    input  wire rhht_pkg::job_t job,
    output logic                job_pop,
    output logic                init_done,
    input  wire logic           cfg_we,
    input  wire logic [10:0]    cfg_wdata,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rhht_pkg::out_t      m_data
);
    import rhht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LK_RD, S_LK_CHK, S_IN_RD, S_IN_CHK,
        S_RM_CLR, S_RM_RD, S_RM_CHK, S_RM_MV2, S_RESP
    } state_t;

    // slot memory
    word_t mem [SLOTS];
    word_t rdata_reg;
    logic  we;
    logic [SLOT_W-1:0] waddr;
    word_t wdata;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_BITS-1:0]   okey_reg, okey_next;
    logic [63:0]           ohash_reg, ohash_next;
    logic [KEY_BITS-1:0]   ckey_reg, ckey_next;
    logic [63:0]           chash_reg, chash_next;
    logic [VALUE_BITS-1:0] cval_reg, cval_next;
    logic [SLOT_W-1:0]     addr_reg, addr_next;
    logic [SLOT_W-1:0]     i_reg, i_next;
    logic [COUNT_W-1:0]    d_reg, d_next;
    logic [COUNT_W-1:0]    step_reg, step_next;
    logic [COUNT_W-1:0]    occ_reg, occ_next;
    logic [10:0]           max_reg, max_next;
    logic [1:0]            st_reg, st_next;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic               q_empty, q_match, q_inside, hit, miss, no_room;
    logic [COUNT_W-1:0] q_dist;
    logic [SLOT_W-1:0]  q_home;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb begin
        q_empty  = (rdata_reg.tag == TAG_EMPTY);
        q_match  = (rdata_reg.tag == {1'b0, ohash_reg[6:0]}) && (rdata_reg.hash == ohash_reg)
                   && (rdata_reg.key == okey_reg);
        q_home   = rdata_reg.hash[SLOT_W-1:0];
        q_dist   = COUNT_W'(SLOT_W'(addr_reg - q_home));
        q_inside = (i_reg < addr_reg) ? ((i_reg < q_home) && (q_home <= addr_reg))
                                      : ((i_reg < q_home) || (q_home <= addr_reg));
        no_room  = (32'(occ_reg) + 32'd1 > 32'(max_reg)) || (32'(occ_reg) >= 32'(SLOTS));
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        okey_next    = okey_reg;
        ohash_next   = ohash_reg;
        ckey_next    = ckey_reg;
        chash_next   = chash_reg;
        cval_next    = cval_reg;
        addr_next    = addr_reg;
        i_next       = i_reg;
        d_next       = d_reg;
        step_next    = step_reg;
        occ_next     = occ_reg;
        max_next     = cfg_we ? cfg_wdata : max_reg;
        st_next      = st_reg;
        fval_next    = fval_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        job_pop      = 1'b0;
        we           = 1'b0;
        waddr        = addr_reg;
        wdata        = EMPTY_WORD;
        hit          = 1'b0;
        miss         = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                we        = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    op_next    = job.op;
                    okey_next  = job.key;
                    ohash_next = job.hash;
                    ckey_next  = job.key;
                    chash_next = job.hash;
                    cval_next  = job.value;
                    addr_next  = job.hash[SLOT_W-1:0];
                    d_next     = '0;
                    fval_next  = '0;
                    if (job.op == OP_INVALID) begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_LK_RD;
                    end
                end
            end
            S_LK_RD: state_next = S_LK_CHK;
            S_LK_CHK: begin
                if (q_empty) begin
                    miss = 1'b1;
                end else if (q_match) begin
                    hit = 1'b1;
                end else if (q_dist < d_reg || d_reg == COUNT_W'(SLOTS - 1)) begin
                    miss = 1'b1;
                end else begin
                    d_next     = d_reg + 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_LK_RD;
                end
                if (hit) begin
                    case (op_reg)
                        OP_LOOKUP: begin
                            st_next    = ST_OK;
                            fval_next  = rdata_reg.value;
                            state_next = S_RESP;
                        end
                        OP_REMOVE: begin
                            i_next     = addr_reg;
                            state_next = S_RM_CLR;
                        end
                        default: begin
                            st_next    = ST_EXISTS;
                            state_next = S_RESP;
                        end
                    endcase
                end
                if (miss) begin
                    if (op_reg == OP_INSERT && !no_room) begin
                        addr_next  = ohash_reg[SLOT_W-1:0];
                        d_next     = '0;
                        step_next  = '0;
                        state_next = S_IN_RD;
                    end else begin
                        st_next    = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        state_next = S_RESP;
                    end
                end
            end
            S_IN_RD: state_next = S_IN_CHK;
            S_IN_CHK: begin
                wdata = '{tag: {1'b0, chash_reg[6:0]}, hash: chash_reg,
                          key: ckey_reg, value: cval_reg};
                if (q_empty) begin
                    we         = 1'b1;
                    occ_next   = occ_reg + 1'b1;
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end else begin
                    // displace the richer occupant and carry it on
                    if (d_reg > q_dist) begin
                        we         = 1'b1;
                        chash_next = rdata_reg.hash;
                        ckey_next  = rdata_reg.key;
                        cval_next  = rdata_reg.value;
                        d_next     = q_dist + 1'b1;
                    end else begin
                        d_next = d_reg + 1'b1;
                    end
                    addr_next = addr_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == COUNT_W'(SLOTS - 1)) begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_IN_RD;
                    end
                end
            end
            S_RM_CLR: begin
                we         = 1'b1;
                waddr      = i_reg;
                occ_next   = occ_reg - 1'b1;
                addr_next  = i_reg + 1'b1;
                step_next  = '0;
                st_next    = ST_OK;
                state_next = S_RM_RD;
            end
            S_RM_RD: state_next = S_RM_CHK;
            S_RM_CHK: begin
                step_next = step_reg + 1'b1;
                if (q_empty) begin
                    state_next = S_RESP;
                end else if (!q_inside) begin
                    // shift this entry back into the hole
                    we         = 1'b1;
                    waddr      = i_reg;
                    wdata      = rdata_reg;
                    i_next     = addr_reg;
                    state_next = S_RM_MV2;
                end else begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = (step_reg == COUNT_W'(SLOTS - 1)) ? S_RESP : S_RM_RD;
                end
            end
            S_RM_MV2: begin
                we         = 1'b1;
                addr_next  = addr_reg + 1'b1;
                state_next = (step_reg == COUNT_W'(SLOTS)) ? S_RESP : S_RM_RD;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = st_reg;
                    m_data_next.found_value = 64'(fval_reg);
                    m_data_next.entry_count = 11'(occ_reg);
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            occ_reg     <= '0;
            max_reg     <= MAX_DEFAULT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            occ_reg     <= occ_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        okey_reg   <= okey_next;
        ohash_reg  <= ohash_next;
        ckey_reg   <= ckey_next;
        chash_reg  <= chash_next;
        cval_reg   <= cval_next;
        i_reg      <= i_next;
        d_reg      <= d_next;
        step_reg   <= step_next;
        st_reg     <= st_next;
        fval_reg   <= fval_next;
        m_data_reg <= m_data_next;
    end

    assign init_done = (state_reg != S_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

// File: hdl/rhht_checker.sv
`default_nettype none
`include "robin_hood_hash_table_macros.svh"

module rhht_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire rhht_pkg::in_t  s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire rhht_pkg::out_t m_data
);
    import rhht_pkg::*;

    `RHHT_ASSERT(a_input_held, s_valid && !s_ready |=> s_valid && $stable(s_data), "input changed")
    `RHHT_ASSERT(a_result_held,
        m_valid && !m_ready |=> m_valid && $stable(m_data),
        "result dropped while stalled")
    `RHHT_NEVER(a_count_range,
        m_valid && (32'(m_data.entry_count) > 32'(SLOTS)),
        "entry count beyond capacity")
    `RHHT_NEVER(a_value_only_ok,
        m_valid && (m_data.status != ST_OK) && (m_data.found_value != 64'd0),
        "value on failed transaction")

endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (.*);

`default_nettype wire
